// File: rtl/sfa_pkg.sv
// ----------------------------------------------------------------------------
// sfa_pkg: shared types, widths and helpers of the separation force block
// Fixed-point formats, derived widths, saturation helpers and state codes.
// ----------------------------------------------------------------------------
package sfa_pkg;

   // Position format: signed Q(POS_WIDTH-FRAC_BITS).FRAC_BITS
   localparam int POS_WIDTH = 32;
   localparam int FRAC_BITS = 16;

   // Minimum separation register: unsigned, 31 bits
   localparam int MINSEP_W = 31;
   localparam logic [MINSEP_W-1:0] MINSEP_RESET = 31'd327680;

   // Softening term added to the length: round(0.001 * 2^FRAC_BITS)
   localparam int EPS = ((1 << FRAC_BITS) + 500) / 1000;

   // Offset and magnitude widths
   localparam int DIFF_W = POS_WIDTH + 1;
   localparam int CHK_W  = (DIFF_W > MINSEP_W) ? DIFF_W : MINSEP_W;
   localparam int MAG_W  = MINSEP_W;

   // Shared multiplier, sum of squares and root
   localparam int MUL_B_W     = MAG_W + 1;
   localparam int PROD_W      = 2 * MAG_W + 1;
   localparam int SQ_W        = 2 * MAG_W + 2;
   localparam int ROOT_W      = SQ_W / 2;
   localparam int SQRT_CNT_W  = $clog2(ROOT_W);

   // Divider: quotient of |d| * 2^(2F) / den
   localparam int DEN_W      = PROD_W;
   localparam int QUO_W      = 2 * FRAC_BITS + 1;
   localparam int DIV_CNT_W  = $clog2(QUO_W);
   localparam int SAT_W      = ((QUO_W > POS_WIDTH) ? QUO_W : POS_WIDTH) + 1;

   // Stream payload widths, padded to whole bytes
   localparam int REQ_DATA_W = ((6 * POS_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((3 * POS_WIDTH + 7) / 8) * 8;

   // Square sequencing: three products, last add, root start
   localparam int SQ_CNT_W = 3;
   localparam logic [SQ_CNT_W-1:0] SQ_LAST_MUL = 3'd2;
   localparam logic [SQ_CNT_W-1:0] SQ_START    = 3'd4;

   typedef logic signed [POS_WIDTH-1:0] pos_type;
   typedef logic signed [DIFF_W-1:0]    diff_type;
   typedef logic        [MAG_W-1:0]     mag_type;
   typedef logic        [DEN_W-1:0]     den_type;
   typedef logic        [QUO_W-1:0]     quo_type;

   localparam pos_type POS_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
   localparam pos_type POS_MIN = {1'b1, {(POS_WIDTH-1){1'b0}}};

   // Sequencer states
   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_CHECK    = 9'b000000010,
      ST_SQUARE   = 9'b000000100,
      ST_ROOT     = 9'b000001000,
      ST_MULDEN   = 9'b000010000,
      ST_DIVSTART = 9'b000100000,
      ST_DIVIDE   = 9'b001000000,
      ST_ACCUM    = 9'b010000000,
      ST_FINISH   = 9'b100000000
   } state_type;

   // Magnitude of an offset, widened for the range compare
   function automatic logic [CHK_W-1:0] abs_diff(diff_type d);
      logic [DIFF_W-1:0] m;
      m = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
      return CHK_W'(m);
   endfunction

   // Apply the offset sign to a quotient and clamp to the position range
   function automatic pos_type term_sat(quo_type q, logic neg);
      logic [SAT_W-1:0] qe;
      logic [SAT_W-1:0] lim;
      qe  = SAT_W'(q);
      lim = SAT_W'(1) << (POS_WIDTH - 1);
      if (neg) begin
         if (qe >= lim) return POS_MIN;
         return pos_type'(-(qe[POS_WIDTH-1:0]));
      end
      if (qe >= lim) return POS_MAX;
      return pos_type'(qe[POS_WIDTH-1:0]);
   endfunction

   // Saturating add in the position range
   function automatic pos_type sat_add(pos_type a, pos_type b);
      logic signed [POS_WIDTH:0] s;
      s = (POS_WIDTH+1)'(a) + (POS_WIDTH+1)'(b);
      if (s[POS_WIDTH] != s[POS_WIDTH-1]) begin
         return s[POS_WIDTH] ? POS_MIN : POS_MAX;
      end
      return pos_type'(s[POS_WIDTH-1:0]);
   endfunction

endpackage

// File: rtl/sfa_sqrt.sv
// ----------------------------------------------------------------------------
// sfa_sqrt: digit-serial integer square root
// Floor root of the sum of squares, one result bit per cycle; the radicand
// leaves a shift register two bits at a time.
// ----------------------------------------------------------------------------
module sfa_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [sfa_pkg::SQ_W-1:0]   radicand,
   output logic                       done,
   output logic [sfa_pkg::ROOT_W-1:0] root
);

   localparam int T_W = sfa_pkg::ROOT_W + 3;

   logic [sfa_pkg::SQ_W-1:0]       rad_ff, rad_in;
   logic [sfa_pkg::ROOT_W:0]       rem_ff, rem_in;
   logic [sfa_pkg::ROOT_W-1:0]     root_ff, root_in;
   logic [sfa_pkg::SQRT_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [T_W-1:0]                 t;
   logic [T_W-1:0]                 trial;

   // One root digit: bring down two radicand bits, try (4*root + 1)
   always_comb begin
      t       = {rem_ff, rad_ff[sfa_pkg::SQ_W-1 -: 2]};
      trial   = T_W'({root_ff, 2'b01});
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = rad_ff << 2;
         if (t >= trial) begin
            rem_in  = (sfa_pkg::ROOT_W+1)'(t - trial);
            root_in = {root_ff[sfa_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = t[sfa_pkg::ROOT_W:0];
            root_in = {root_ff[sfa_pkg::ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == sfa_pkg::SQRT_CNT_W'(sfa_pkg::ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// File: rtl/sfa_div.sv
// ----------------------------------------------------------------------------
// sfa_div: bit-serial restoring divider
// Quotient of numer * 2^(2F) / denom, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sfa_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  sfa_pkg::mag_type          numer,
   input  sfa_pkg::den_type          denom,
   output logic                      done,
   output sfa_pkg::quo_type          quo
);

   localparam int T_W = sfa_pkg::DEN_W + 1;

   sfa_pkg::den_type              rem_ff, rem_in;
   sfa_pkg::den_type              den_ff, den_in;
   sfa_pkg::quo_type              quo_ff, quo_in;
   logic                          bit_ff, bit_in;
   logic [sfa_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [T_W-1:0]                t;
   logic [T_W-1:0]                den_ext;

   // Shift in the next numerator bit, subtract when the divisor fits
   always_comb begin
      t       = {rem_ff, bit_ff};
      den_ext = T_W'(den_ff);
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         // Upper numerator bits preload the remainder; the low bit follows
         rem_in  = sfa_pkg::DEN_W'(numer >> 1);
         bit_in  = numer[0];
         den_in  = denom;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         bit_in = 1'b0;
         if (t >= den_ext) begin
            rem_in = sfa_pkg::DEN_W'(t - den_ext);
            quo_in = {quo_ff[sfa_pkg::QUO_W-2:0], 1'b1};
         end else begin
            rem_in = t[sfa_pkg::DEN_W-1:0];
            quo_in = {quo_ff[sfa_pkg::QUO_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == sfa_pkg::DIV_CNT_W'(sfa_pkg::QUO_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      bit_ff <= bit_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// File: rtl/separation_force_accumulator.sv
// ----------------------------------------------------------------------------
// separation_force_accumulator: separation force summed over a neighbor list
// One beat at a time: a close neighbor passes the 32-step root and the 33-step
// divider lanes at one bit per cycle; a neighbor that the length rejects skips the
// divide, and an absent or far neighbor skips both. The result is registered in
// the finish state of the last beat; a full result slot stalls the input.
// Synchronous reset clears the sums, the pending result and sets the repel distance to 5.0.
// ----------------------------------------------------------------------------
module separation_force_accumulator (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: own_x, own_y, own_z, nbr_x, nbr_y, nbr_z (lowest first)
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [sfa_pkg::REQ_DATA_W-1:0]     req_tdata,
   // req_tuser: present
   input  logic                               req_tuser,
   input  logic                               req_tlast,
   // rsp_tdata: force_x, force_y, force_z (lowest first)
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [sfa_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // repel distance write, unsigned Q15.16
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [sfa_pkg::MINSEP_W-1:0]       csr_data
);

   localparam int W = sfa_pkg::POS_WIDTH;

   sfa_pkg::state_type              state_ff, state_in;
   logic [sfa_pkg::MINSEP_W-1:0]    minsep_ff, minsep_in;
   sfa_pkg::diff_type               d_ff [3];
   sfa_pkg::diff_type               d_in [3];
   sfa_pkg::mag_type                mag_ff [3];
   sfa_pkg::mag_type                mag_in [3];
   logic                            neg_ff [3];
   logic                            neg_in [3];
   sfa_pkg::pos_type                sum_ff [3];
   sfa_pkg::pos_type                sum_in [3];
   logic                            present_ff, present_in;
   logic                            last_ff, last_in;
   logic [sfa_pkg::SQ_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [sfa_pkg::PROD_W-1:0]      prod_ff, prod_in;
   logic [sfa_pkg::SQ_W-1:0]        ssq_ff, ssq_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [sfa_pkg::RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   logic [sfa_pkg::CHK_W-1:0]       chk_mag [3];
   logic                            far;
   sfa_pkg::mag_type                mul_a;
   logic [sfa_pkg::MUL_B_W-1:0]     mul_b;
   sfa_pkg::mag_type                len;
   sfa_pkg::pos_type                own [3];
   sfa_pkg::pos_type                nbr [3];

   logic                            sqrt_start;
   logic                            sqrt_done;
   logic [sfa_pkg::ROOT_W-1:0]      root;
   logic                            div_start;
   logic [2:0]                      div_done;
   sfa_pkg::quo_type                quo [3];

   // Unpack the request beat
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         own[k] = sfa_pkg::pos_type'(req_tdata[k*W +: W]);
         nbr[k] = sfa_pkg::pos_type'(req_tdata[(k+3)*W +: W]);
      end
   end

   // Range screen on the offset magnitudes
   always_comb begin
      far = 1'b0;
      for (int k = 0; k < 3; k++) begin
         chk_mag[k] = sfa_pkg::abs_diff(d_ff[k]);
         if (chk_mag[k] >= sfa_pkg::CHK_W'(minsep_ff)) far = 1'b1;
      end
   end

   // Shared multiplier: squares of the magnitudes, then len * (len + eps)
   assign len = root[sfa_pkg::MAG_W-1:0];
   always_comb begin
      if (state_ff == sfa_pkg::ST_MULDEN) begin
         mul_a = len;
         mul_b = sfa_pkg::MUL_B_W'(len) + sfa_pkg::MUL_B_W'(sfa_pkg::EPS);
      end else begin
         mul_a = mag_ff[0];
         mul_b = sfa_pkg::MUL_B_W'(mag_ff[0]);
      end
      prod_in = sfa_pkg::PROD_W'(mul_a) * sfa_pkg::PROD_W'(mul_b);
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      minsep_in    = minsep_ff;
      present_in   = present_ff;
      last_in      = last_ff;
      cnt_in       = cnt_ff;
      ssq_in       = ssq_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      sqrt_start   = 1'b0;
      div_start    = 1'b0;
      for (int k = 0; k < 3; k++) begin
         d_in[k]   = d_ff[k];
         mag_in[k] = mag_ff[k];
         neg_in[k] = neg_ff[k];
         sum_in[k] = sum_ff[k];
      end

      // Take a register write
      if (csr_valid) minsep_in = csr_data;

      // Drop the result once taken
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         sfa_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               for (int k = 0; k < 3; k++) begin
                  d_in[k] = sfa_pkg::diff_type'(own[k]) - sfa_pkg::diff_type'(nbr[k]);
               end
               present_in = req_tuser;
               last_in    = req_tlast;
               state_in   = sfa_pkg::ST_CHECK;
            end
         end
         sfa_pkg::ST_CHECK: begin
            for (int k = 0; k < 3; k++) begin
               mag_in[k] = chk_mag[k][sfa_pkg::MAG_W-1:0];
               neg_in[k] = d_ff[k][sfa_pkg::DIFF_W-1];
            end
            cnt_in = '0;
            ssq_in = '0;
            if (!present_ff || far) state_in = sfa_pkg::ST_FINISH;
            else                    state_in = sfa_pkg::ST_SQUARE;
         end
         sfa_pkg::ST_SQUARE: begin
            // Rotate the magnitudes past the multiplier, sum the products
            if (cnt_ff <= sfa_pkg::SQ_LAST_MUL) begin
               mag_in[0] = mag_ff[1];
               mag_in[1] = mag_ff[2];
               mag_in[2] = mag_ff[0];
            end
            if (cnt_ff != '0 && cnt_ff != sfa_pkg::SQ_START) begin
               ssq_in = ssq_ff + sfa_pkg::SQ_W'(prod_ff);
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == sfa_pkg::SQ_START) begin
               sqrt_start = 1'b1;
               state_in   = sfa_pkg::ST_ROOT;
            end
         end
         sfa_pkg::ST_ROOT: begin
            if (sqrt_done) begin
               if (root == '0 || root >= sfa_pkg::ROOT_W'(minsep_ff)) begin
                  state_in = sfa_pkg::ST_FINISH;
               end else begin
                  state_in = sfa_pkg::ST_MULDEN;
               end
            end
         end
         sfa_pkg::ST_MULDEN: begin
            state_in = sfa_pkg::ST_DIVSTART;
         end
         sfa_pkg::ST_DIVSTART: begin
            div_start = 1'b1;
            state_in  = sfa_pkg::ST_DIVIDE;
         end
         sfa_pkg::ST_DIVIDE: begin
            if (&div_done) state_in = sfa_pkg::ST_ACCUM;
         end
         sfa_pkg::ST_ACCUM: begin
            for (int k = 0; k < 3; k++) begin
               sum_in[k] = sfa_pkg::sat_add(sum_ff[k], sfa_pkg::term_sat(quo[k], neg_ff[k]));
            end
            state_in = sfa_pkg::ST_FINISH;
         end
         sfa_pkg::ST_FINISH: begin
            // Emit and clear on the last beat, hold while the result slot is full
            if (!last_ff) begin
               state_in = sfa_pkg::ST_IDLE;
            end else if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = sfa_pkg::RSP_DATA_W'({sum_ff[2], sum_ff[1], sum_ff[0]});
               rsp_valid_in = 1'b1;
               for (int k = 0; k < 3; k++) sum_in[k] = '0;
               state_in = sfa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sfa_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      present_ff  <= present_in;
      last_ff     <= last_in;
      prod_ff     <= prod_in;
      ssq_ff      <= ssq_in;
      rsp_data_ff <= rsp_data_in;
      for (int k = 0; k < 3; k++) begin
         d_ff[k]   <= d_in[k];
         mag_ff[k] <= mag_in[k];
         neg_ff[k] <= neg_in[k];
      end
      if (reset) begin
         state_ff     <= sfa_pkg::ST_IDLE;
         minsep_ff    <= sfa_pkg::MINSEP_RESET;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 3; k++) sum_ff[k] <= '0;
      end else begin
         state_ff     <= state_in;
         minsep_ff    <= minsep_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int k = 0; k < 3; k++) sum_ff[k] <= sum_in[k];
      end
   end

   // Length of the offset
   sfa_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (ssq_ff),
      .done     (sqrt_done),
      .root     (root)
   );

   // One divider lane per axis
   for (genvar g = 0; g < 3; g++) begin : g_div
      sfa_div u_div (
         .clock (clock),
         .reset (reset),
         .start (div_start),
         .numer (mag_ff[g]),
         .denom (prod_ff),
         .done  (div_done[g]),
         .quo   (quo[g])
      );
   end

   assign req_tready = (state_ff == sfa_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

endmodule

// File: tb/sv/separation_force_accumulator_tb.sv
// ----------------------------------------------------------------------------
// separation_force_accumulator_tb: self-checking bench of the separation force
// Streams neighbor lists through the block, idling at random on both sides but in
// a closing run, predicts each summed force in fixed point and checks every result beat.
// ----------------------------------------------------------------------------
module separation_force_accumulator_tb;

   localparam int POS_WIDTH  = sfa_pkg::POS_WIDTH;
   localparam int FRAC_BITS  = sfa_pkg::FRAC_BITS;
   localparam int MINSEP_W   = sfa_pkg::MINSEP_W;
   localparam int REQ_DATA_W = sfa_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W = sfa_pkg::RSP_DATA_W;

   typedef sfa_pkg::pos_type pos_type;
   typedef longint unsigned  u64_type;

   localparam pos_type FORCE_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
   localparam pos_type FORCE_MIN = {1'b1, {(POS_WIDTH-1){1'b0}}};
   localparam pos_type ONE       = pos_type'(1 << FRAC_BITS);
   localparam u64_type SOFTEN    = ((64'd1 << FRAC_BITS) + 500) / 1000;
   localparam logic [MINSEP_W-1:0] SEP_RESET = 31'd327680;
   localparam logic [MINSEP_W-1:0] SEP_TOP   = {MINSEP_W{1'b1}};
   localparam int SETTLE_CYCLES = 200;
   localparam int RUN_LIMIT     = 20_000_000;

   typedef struct packed {
      pos_type own_x, own_y, own_z;
      pos_type nbr_x, nbr_y, nbr_z;
      logic    present;
      logic    last;
   } beat_type;

   typedef struct packed {
      pos_type x, y, z;
   } force_type;

   typedef struct packed {
      beat_type b;
      logic     zero_force;
   } row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic                    req_tuser = 1'b0;
   logic                    req_tlast = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [MINSEP_W-1:0]     csr_data = '0;

   // Predictor state: running force and repel distance
   pos_type             sum_x = '0, sum_y = '0, sum_z = '0;
   logic [MINSEP_W-1:0] min_sep = SEP_RESET;

   force_type force_q[$];
   row_type   script[$];
   int        mismatches = 0;
   int        beats_sent = 0;
   bit        idling = 1'b1;
   int        stall_left = 0;

   separation_force_accumulator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // Floor of the square root, one result bit per step
   function automatic u64_type floor_sqrt(u64_type n);
      u64_type root, trial;
      int b;
      root = 0;
      for (b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= n) root = trial;
      end
      return root;
   endfunction

   // |d| * 2^(2F) / den, signed and clamped to the position range
   function automatic pos_type force_term(longint d, u64_type den);
      u64_type m, q;
      m = (d < 0) ? u64_type'(-d) : u64_type'(d);
      q = (m << (2 * FRAC_BITS)) / den;
      if (q >= (64'd1 << (POS_WIDTH - 1))) return (d < 0) ? FORCE_MIN : FORCE_MAX;
      return (d < 0) ? pos_type'(-longint'(q)) : pos_type'(q);
   endfunction

   function automatic pos_type add_clamped(pos_type a, pos_type b);
      longint s;
      s = longint'(a) + longint'(b);
      if (s > longint'(FORCE_MAX)) return FORCE_MAX;
      if (s < longint'(FORCE_MIN)) return FORCE_MIN;
      return pos_type'(s);
   endfunction

   // Fold one beat into the running force; report whether a result follows
   function automatic logic advance_sums(input beat_type b, output force_type f);
      longint  dx, dy, dz;
      u64_type ax, ay, az, len, den;
      f = '0;
      if (b.present) begin
         dx = longint'($signed(b.own_x)) - longint'($signed(b.nbr_x));
         dy = longint'($signed(b.own_y)) - longint'($signed(b.nbr_y));
         dz = longint'($signed(b.own_z)) - longint'($signed(b.nbr_z));
         ax = (dx < 0) ? u64_type'(-dx) : u64_type'(dx);
         ay = (dy < 0) ? u64_type'(-dy) : u64_type'(dy);
         az = (dz < 0) ? u64_type'(-dz) : u64_type'(dz);
         if (ax < min_sep && ay < min_sep && az < min_sep) begin
            len = floor_sqrt(ax * ax + ay * ay + az * az);
            if (len != 0 && len < min_sep) begin
               den   = len * (len + SOFTEN);
               sum_x = add_clamped(sum_x, force_term(dx, den));
               sum_y = add_clamped(sum_y, force_term(dy, den));
               sum_z = add_clamped(sum_z, force_term(dz, den));
            end
         end
      end
      if (!b.last) return 1'b0;
      f.x   = sum_x;
      f.y   = sum_y;
      f.z   = sum_z;
      sum_x = '0;
      sum_y = '0;
      sum_z = '0;
      return 1'b1;
   endfunction

   function automatic beat_type mk(pos_type ox, pos_type oy, pos_type oz,
                                   pos_type nx, pos_type ny, pos_type nz,
                                   logic p, logic l);
      beat_type b;
      b.own_x   = ox;
      b.own_y   = oy;
      b.own_z   = oz;
      b.nbr_x   = nx;
      b.nbr_y   = ny;
      b.nbr_z   = nz;
      b.present = p;
      b.last    = l;
      return b;
   endfunction

   function automatic longint spread(int unsigned s);
      return longint'($urandom_range(0, 2 * s)) - longint'(s);
   endfunction

   // Append one row to the directed table
   task automatic add_row(input beat_type b, input logic zero_force);
      row_type r;
      r.b          = b;
      r.zero_force = zero_force;
      script       = {script, r};
   endtask

   // Drive one request beat, wait for the handshake, then predict
   task automatic send_beat(input beat_type b, input logic zero_force);
      int        gap;
      force_type f;
      gap = (idling && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = REQ_DATA_W'({b.nbr_z, b.nbr_y, b.nbr_x, b.own_z, b.own_y, b.own_x});
      req_tuser  = b.present;
      req_tlast  = b.last;
      do @(posedge clock); while (!req_tready);
      if (advance_sums(b, f)) force_q = {force_q, zero_force ? force_type'('0) : f};
      beats_sent++;
   endtask

   // Hold the sender until every force is back and the block has gone quiet
   task automatic settle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (force_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_min_sep(input logic [MINSEP_W-1:0] v);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = v;
      do @(posedge clock); while (!csr_ready);
      min_sep = v;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // One neighbor list around a random agent; pile keeps every offset
   // at one LSB with a fixed sign per axis so the sums run into the clamp
   task automatic send_list(input int n, input bit pile);
      beat_type    b;
      int          k, kind, sx, sy, sz;
      int unsigned reach, scale;
      longint      offx, offy, offz;
      pos_type     ox, oy, oz;
      reach = (min_sep == 0) ? 32'd65536 : 32'(min_sep);
      ox    = pos_type'($urandom);
      oy    = pos_type'($urandom);
      oz    = pos_type'($urandom);
      sx    = $urandom_range(0, 1) ? 1 : -1;
      sy    = $urandom_range(0, 1) ? 1 : -1;
      sz    = $urandom_range(0, 1) ? 1 : -1;
      for (k = 0; k < n; k++) begin
         b.own_x   = ox;
         b.own_y   = oy;
         b.own_z   = oz;
         b.present = 1'b1;
         b.last    = (k == n - 1);
         kind      = pile ? 0 : $urandom_range(0, 9);
         offx      = 0;
         offy      = 0;
         offz      = 0;
         if (pile) begin
            offx = sx;
            offy = sy;
            offz = sz;
         end else if (kind <= 5) begin
            scale = reach >> $urandom_range(0, 6);
            if (scale == 0) scale = 1;
            offx = spread(scale);
            offy = spread(scale);
            offz = spread(scale);
         end else if (kind == 9) begin
            offx = spread(3);
            offy = spread(3);
            offz = spread(3);
         end
         b.nbr_x = pos_type'(longint'(ox) - offx);
         b.nbr_y = pos_type'(longint'(oy) - offy);
         b.nbr_z = pos_type'(longint'(oz) - offz);
         // far neighbor or absent neighbor with junk fields
         if (kind == 6 || kind == 8) begin
            b.nbr_x = pos_type'($urandom);
            b.nbr_y = pos_type'($urandom);
            b.nbr_z = pos_type'($urandom);
         end
         if (kind == 8) b.present = 1'b0;
         if (b.last && !pile && $urandom_range(0, 2) == 0) b.present = 1'b0;
         send_beat(b, 1'b0);
      end
   endtask

   task automatic run_phase(input logic [MINSEP_W-1:0] sep, input int beats);
      int start;
      settle();
      write_min_sep(sep);
      start = beats_sent;
      while (beats_sent - start < beats) begin
         send_list(($urandom_range(0, 7) == 0) ? $urandom_range(9, 24)
                                                : $urandom_range(1, 8), 1'b0);
      end
   endtask

   // Result side: random stall bursts while idling is on
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_tready = 1'b0;
         stall_left--;
      end else if (idling && $urandom_range(0, 5) == 0) begin
         rsp_tready = 1'b0;
         stall_left = $urandom_range(0, 13);
      end else begin
         rsp_tready = 1'b1;
      end
   end

   // Compare each result beat with the oldest predicted force
   always @(posedge clock) begin
      force_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.x = rsp_tdata[POS_WIDTH-1:0];
         got.y = rsp_tdata[2*POS_WIDTH-1:POS_WIDTH];
         got.z = rsp_tdata[3*POS_WIDTH-1:2*POS_WIDTH];
         if (force_q.size() == 0) begin
            $error("force result with nothing expected: %0d %0d %0d",
                   $signed(got.x), $signed(got.y), $signed(got.z));
            mismatches++;
         end else begin
            want = force_q.pop_front();
            if (got.x !== want.x) begin
               $error("force_x: expected %0d, got %0d", $signed(want.x), $signed(got.x));
               mismatches++;
            end
            if (got.y !== want.y) begin
               $error("force_y: expected %0d, got %0d", $signed(want.y), $signed(got.y));
               mismatches++;
            end
            if (got.z !== want.z) begin
               $error("force_z: expected %0d, got %0d", $signed(want.z), $signed(got.z));
               mismatches++;
            end
         end
      end
   end

   initial begin
      #(RUN_LIMIT);
      $display("separation_force_accumulator_tb: errors");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table: own xyz, neighbor xyz, present, last, zero force
      add_row(mk(0, 0, 0, 0, 0, 0, 1'b0, 1'b1), 1'b1);                  // empty list
      add_row(mk(3*ONE, -2*ONE, ONE, 3*ONE, -2*ONE, ONE, 1'b1, 1'b1), 1'b1); // no offset
      add_row(mk(0, 0, 0, 10*ONE, 0, 0, 1'b1, 1'b1), 1'b1);             // far away
      add_row(mk(FORCE_MAX, FORCE_MAX, FORCE_MAX,
                 FORCE_MIN, FORCE_MIN, FORCE_MIN, 1'b1, 1'b1), 1'b1);
      add_row(mk(FORCE_MIN, FORCE_MIN, FORCE_MIN,
                 FORCE_MAX, FORCE_MAX, FORCE_MAX, 1'b1, 1'b1), 1'b1);
      add_row(mk(0, 0, 0, -327680, 0, 0, 1'b1, 1'b1), 1'b1);            // on the threshold
      add_row(mk(0, 0, 0, -327679, 0, 0, 1'b1, 1'b1), 1'b0);            // just inside
      add_row(mk(0, 0, 0, -300000, -300000, 0, 1'b1, 1'b1), 1'b1);      // length outside
      add_row(mk(0, 0, 0, 1, 0, 0, 1'b0, 1'b0), 1'b0);                  // no neighbor, no end
      add_row(mk(0, 0, 0, -ONE, 0, 0, 1'b1, 1'b0), 1'b0);
      add_row(mk(0, 0, 0, 0, 2*ONE, ONE/2, 1'b1, 1'b0), 1'b0);
      add_row(mk(0, 0, 0, 0, 1, 0, 1'b0, 1'b0), 1'b0);                  // ignored neighbor
      add_row(mk(0, 0, 0, 0, 6*ONE, 0, 1'b1, 1'b0), 1'b0);              // far in mid list
      add_row(mk(0, 0, 0, -1, 0, 0, 1'b1, 1'b1), 1'b0);                 // one LSB away
      add_row(mk(FORCE_MAX, FORCE_MAX, FORCE_MAX,
                 FORCE_MAX - 1, FORCE_MAX, FORCE_MAX - 1, 1'b1, 1'b1), 1'b0);
      add_row(mk(FORCE_MIN, FORCE_MIN, FORCE_MIN,
                 FORCE_MIN + 1, FORCE_MIN + 1, FORCE_MIN + 1, 1'b1, 1'b1), 1'b0);
      add_row(mk(ONE, ONE, ONE, 0, 0, 0, 1'b1, 1'b0), 1'b0);
      add_row(mk(ONE, ONE, ONE, 5, 5, 5, 1'b0, 1'b1), 1'b0);            // end keeps the sum
      add_row(mk(0, 0, 0, 0, 0, 0, 1'b0, 1'b1), 1'b1);                  // cleared again
      add_row(mk(-3*ONE, 0, ONE, -3*ONE + 100000, 200000, ONE - 150000, 1'b1, 1'b1),
              1'b0);
      foreach (script[i]) send_beat(script[i].b, script[i].zero_force);

      // Random lists across repel distances, clamp piles at the default
      run_phase(SEP_RESET, 350);
      settle();
      send_list(45, 1'b1);
      send_list(45, 1'b1);
      run_phase(31'd0, 100);
      run_phase(SEP_TOP, 250);
      run_phase(31'd1, 100);
      run_phase(31'd66, 100);
      run_phase(31'($urandom_range(65536, 40 * 65536)), 300);
      run_phase(31'($urandom), 150);

      // Closing stretch at full rate
      idling = 1'b0;
      run_phase(SEP_RESET, 300);
      send_list(45, 1'b1);
      settle();

      if (mismatches == 0 && force_q.size() == 0) begin
         $display("separation_force_accumulator_tb: clean");
      end else begin
         $display("separation_force_accumulator_tb: errors");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/sfa_pkg.sv
rtl/sfa_sqrt.sv
rtl/sfa_div.sv
rtl/separation_force_accumulator.sv
tb/sv/separation_force_accumulator_tb.sv
